/* rtl/plc_pkg.sv */
// ----------------------------------------------------------------------------
// plc_pkg
// Shared widths, action and status codes and the cell command type for the
// positional list engine.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 6;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_APPEND     = 3'd1,
        ACT_INSERT_AT  = 3'd2,
        ACT_TAKE_FRONT = 3'd3,
        ACT_POP_BACK   = 3'd4,
        ACT_DELETE_AT  = 3'd5,
        ACT_REMOVE_ODD = 3'd6,
        ACT_CLEAR      = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MODE_HOLD = 2'd0,
        MODE_INS  = 2'd1,
        MODE_DEL  = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode                 mode;
        logic [CNT_W-1:0]      where;
        logic [DATA_WIDTH-1:0] value;
    } t_cell_cmd;

endpackage

/* rtl/plc_cell.sv */
// ----------------------------------------------------------------------------
// plc_cell
// One list slot: holds, takes its left or right neighbor, or loads a new
// value, depending on the broadcast command and its own index.
// ----------------------------------------------------------------------------
module plc_cell (
    input  logic                          i_clk,
    input  plc_pkg::t_cell_cmd            i_cmd,
    input  logic [plc_pkg::IDX_W-1:0]     i_idx,
    input  logic [plc_pkg::DATA_WIDTH-1:0] i_left,
    input  logic [plc_pkg::DATA_WIDTH-1:0] i_right,
    output logic [plc_pkg::DATA_WIDTH-1:0] o_data
);
    import plc_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [CNT_W-1:0]      w_idx;

    assign w_idx  = CNT_W'(i_idx);
    assign o_data = r_data;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.mode)
            MODE_INS: begin
                if (w_idx > i_cmd.where) begin
                    r_data <= i_left;
                end else if (w_idx == i_cmd.where) begin
                    r_data <= i_cmd.value;
                end
            end
            MODE_DEL: begin
                if (w_idx >= i_cmd.where) begin
                    r_data <= i_right;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/positional_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list held in a row of shifting cells; one action per item,
// one result per item with front, back, count, empty flag and status.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   input   | in        | i_valid / o_ready  | i_action, i_value, i_position
//   result  | out       | o_valid / i_ready  | o_front_value, o_back_value,
//           |           |                    | o_count, o_is_empty, o_status
//
// an accepted item goes to the report state, where the result register loads
// remove odd runs floor(count / 2) neighbor shifts in the odd state, one per cycle
// o_ready is high only while no item is in flight in the cell row
// a waiting result holds the next item in the report state, keeping o_ready low
// reset is synchronous, active low, and empties the list
// ----------------------------------------------------------------------------
module positional_list_engine_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_action,
    input  logic [plc_pkg::VALUE_W-1:0]  i_value,
    input  logic signed [plc_pkg::POS_W-1:0] i_position,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [plc_pkg::VALUE_W-1:0]  o_front_value,
    output logic [plc_pkg::VALUE_W-1:0]  o_back_value,
    output logic [plc_pkg::CNT_W-1:0]    o_count,
    output logic                         o_is_empty,
    output logic [1:0]                   o_status
);
    import plc_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ODD    = 3'b010,
        ST_REPORT = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_held, n_held;
    logic [CNT_W-1:0]      r_odd_pos, n_odd_pos;
    logic [CNT_W-1:0]      r_odd_left, n_odd_left;
    t_status               r_status, n_status;
    t_cell_cmd             w_cmd;

    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_front, r_back;
    logic [CNT_W-1:0]      r_count;
    t_status               r_out_status;

    logic [DATA_WIDTH-1:0] w_slot [CAPACITY];
    logic                  w_accept;
    logic                  w_load;
    logic                  w_full;
    logic                  w_pos_neg;
    logic [CMP_W-1:0]      w_pos_mag;
    logic [CMP_W-1:0]      w_held_ext;
    logic [IDX_W-1:0]      w_back_idx;
    t_action               w_action;

    assign w_action   = t_action'(i_action);
    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_load     = (r_state == ST_REPORT) && (!r_out_valid || i_ready);
    assign w_full     = (r_held == CAP_CNT);
    assign w_pos_neg  = i_position[POS_W-1];
    assign w_pos_mag  = CMP_W'(i_position[POS_W-2:0]);
    assign w_held_ext = CMP_W'(r_held);
    assign w_back_idx = IDX_W'(r_held - ONE_CNT);

    always_comb begin
        n_state        = r_state;
        n_held         = r_held;
        n_odd_pos      = r_odd_pos;
        n_odd_left     = r_odd_left;
        n_status       = r_status;
        w_cmd.mode     = MODE_HOLD;
        w_cmd.where    = '0;
        w_cmd.value    = i_value[DATA_WIDTH-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state  = ST_REPORT;
                    n_status = STAT_DONE;
                    unique case (w_action)
                        ACT_PUSH_FRONT, ACT_APPEND, ACT_INSERT_AT: begin
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_cmd.mode = MODE_INS;
                                n_held     = r_held + ONE_CNT;
                                if (w_action == ACT_APPEND) begin
                                    w_cmd.where = r_held;
                                end else if (w_action == ACT_PUSH_FRONT
                                             || w_pos_neg || w_pos_mag == '0) begin
                                    w_cmd.where = '0;
                                end else if (w_pos_mag >= w_held_ext) begin
                                    w_cmd.where = r_held;
                                end else begin
                                    w_cmd.where = CNT_W'(w_pos_mag);
                                end
                            end
                        end
                        ACT_TAKE_FRONT, ACT_POP_BACK: begin
                            if (r_held == '0) begin
                                n_status = STAT_IGNORED;
                            end else begin
                                w_cmd.mode  = MODE_DEL;
                                w_cmd.where = (w_action == ACT_POP_BACK)
                                              ? r_held - ONE_CNT : '0;
                                n_held      = r_held - ONE_CNT;
                            end
                        end
                        ACT_DELETE_AT: begin
                            if (w_pos_neg || w_pos_mag >= w_held_ext) begin
                                n_status = STAT_IGNORED;
                            end else begin
                                w_cmd.mode  = MODE_DEL;
                                w_cmd.where = CNT_W'(w_pos_mag);
                                n_held      = r_held - ONE_CNT;
                            end
                        end
                        ACT_REMOVE_ODD: begin
                            if (r_held >= CNT_W'(2)) begin
                                n_state    = ST_ODD;
                                n_odd_pos  = ONE_CNT;
                                n_odd_left = r_held >> 1;
                            end
                        end
                        default: begin
                            n_held = '0;
                        end
                    endcase
                end
            end
            ST_ODD: begin
                w_cmd.mode  = MODE_DEL;
                w_cmd.where = r_odd_pos;
                n_held      = r_held - ONE_CNT;
                n_odd_pos   = r_odd_pos + ONE_CNT;
                n_odd_left  = r_odd_left - ONE_CNT;
                if (r_odd_left == ONE_CNT) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_odd_pos  <= n_odd_pos;
        r_odd_left <= n_odd_left;
        r_status   <= n_status;
        if (w_load) begin
            r_count      <= r_held;
            r_out_status <= r_status;
            if (r_held == '0) begin
                r_front <= '0;
                r_back  <= '0;
            end else begin
                r_front <= VALUE_W'(w_slot[0]);
                r_back  <= VALUE_W'(w_slot[w_back_idx]);
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left, w_right;
        if (g == 0) begin : g_first
            assign w_left = w_slot[g];
        end else begin : g_mid_l
            assign w_left = w_slot[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_slot[g];
        end else begin : g_mid_r
            assign w_right = w_slot[g+1];
        end
        plc_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_idx   (IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_slot[g])
        );
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_count       = r_count;
    assign o_is_empty    = (r_count == '0);
    assign o_status      = r_out_status;

endmodule

/* rtl/plc_checker.sv */
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks on the result channel of the positional list engine.
// ----------------------------------------------------------------------------
module plc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [plc_pkg::VALUE_W-1:0] o_front_value,
    input logic [plc_pkg::VALUE_W-1:0] o_back_value,
    input logic [plc_pkg::CNT_W-1:0]   o_count,
    input logic                        o_is_empty,
    input logic [1:0]                  o_status
);
    import plc_pkg::*;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_front_value == '0 && o_back_value == '0)
        else $error("empty list reports nonzero values");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_count == CNT_W'(1) |-> o_front_value == o_back_value)
        else $error("one element but front and back differ");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_front_value)
                                && $stable(o_status))
        else $error("stalled item changed");

endmodule

bind positional_list_engine_unit plc_checker u_plc_checker (.*);
